// ----- hdl/bxds_pkg.sv -----
package bxds_pkg;

    localparam int unsigned DIM_W   = 9;
    localparam int unsigned COORD_W = 8;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned PIX_W   = 3 * CH_W;
    localparam int unsigned Q_W     = 9;
    localparam int unsigned AREA_W  = 2 * DIM_W;
    localparam int unsigned SUM_W   = AREA_W + CH_W;
    localparam int unsigned DIVS_W  = AREA_W;
    localparam int unsigned DIVD_W  = SUM_W;
    localparam int unsigned CNT_W   = $clog2(Q_W);

    typedef enum logic
    {
        ACT_LOAD    = 1'b0,
        ACT_COMPUTE = 1'b1
    } act_t;

    typedef enum logic [1:0]
    {
        ERR_OK    = 2'd0,
        ERR_SIZE  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic [1:0]
    {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_THUMB_WIDTH   = 2'd2,
        CFG_THUMB_HEIGHT  = 2'd3
    } cfg_idx_t;

    localparam logic [DIM_W-1:0] SOURCE_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RST = 9'd256;
    localparam logic [DIM_W-1:0] THUMB_WIDTH_RST   = 9'd32;
    localparam logic [DIM_W-1:0] THUMB_HEIGHT_RST  = 9'd32;

    typedef struct packed
    {
        act_t               action;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CH_W-1:0]    red_in;
        logic [CH_W-1:0]    green_in;
        logic [CH_W-1:0]    blue_in;
    } req_t;

    typedef struct packed
    {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        err_t            error;
    } rsp_t;

endpackage

// ----- hdl/bxds_div.sv -----
module bxds_div
    import bxds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] rem_next;
    logic [DIVD_W-1:0] dsh_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              ge;

    // quotient is known to fit Q_W bits, so the divisor starts shifted by Q_W-1
    assign ge       = rem_reg >= dsh_reg;
    assign rem_next = ge ? rem_reg - dsh_reg : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                rem_reg <= dividend;
                dsh_reg <= DIVD_W'(divisor) << (Q_W - 1);
                quo_reg <= '0;
                cnt_reg <= CNT_W'(Q_W - 1);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                dsh_reg <= dsh_reg >> 1;
                quo_reg <= {quo_reg[Q_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/bxds_store.sv -----
module bxds_store
    import bxds_pkg::*;
#(
    parameter int unsigned DEPTH  = 65536,
    parameter int unsigned ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data,
    output logic              rd_valid
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ----- hdl/box_average_image_downscale_unit.sv -----
// box average image downscaler
//
// request channel: a request is taken at a rising edge with start high and
// busy low. action load writes one source pixel into the frame store at
// (row, col) and gives no result; busy stays low. action compute names
// one thumbnail pixel. size and range errors answer in the cycle after
// start with colors zero. otherwise the block walks the source box at one
// frame store read per cycle and runs seven divisions (four box edges,
// three channel means) on one shared radix-2 divider of nine steps each.
// busy is high for the whole compute, so one request is at work at a time.
// result channel: done is high for exactly one cycle with the result;
// the receiver cannot stall, so nothing waits for it.
// configuration: cfg_valid/cfg_ready write one size register by cfg_index,
// ready is always high; write only while idle.
// reset: sizes return to 256x256 source and 32x32 thumbnail; the frame
// store is not cleared and needs no clearing pass.
module box_average_image_downscale_unit
    import bxds_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_WIDTH  = 256,
    parameter int unsigned MAX_SOURCE_HEIGHT = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_idx_t         cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int unsigned DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SETUP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_AREA,
        S_WALK,
        S_DRAIN
    } state_t;

    typedef enum logic [2:0]
    {
        OP_LO_X,
        OP_HI_X,
        OP_LO_Y,
        OP_HI_Y,
        OP_BLUE,
        OP_GREEN,
        OP_RED
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [DIM_W-1:0] source_width_reg;
    logic [DIM_W-1:0] source_height_reg;
    logic [DIM_W-1:0] thumb_width_reg;
    logic [DIM_W-1:0] thumb_height_reg;

    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [AREA_W-1:0]  cx_reg;
    logic [AREA_W-1:0]  cy_reg;
    logic [DIM_W-1:0]   x0_reg;
    logic [DIM_W-1:0]   x1_reg;
    logic [DIM_W-1:0]   y0_reg;
    logic [DIM_W-1:0]   y1_reg;
    logic [DIM_W-1:0]   sx_reg;
    logic [DIM_W-1:0]   sy_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [SUM_W-1:0]   sum_r_reg;
    logic [SUM_W-1:0]   sum_g_reg;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [CH_W-1:0]    mean_b_reg;
    logic [CH_W-1:0]    mean_g_reg;
    logic               done_reg;
    rsp_t               result_reg;

    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    err_t             cmp_err;
    logic             accept;
    logic             load_ok;
    logic [DIM_W-1:0] box_w;
    logic [DIM_W-1:0] box_h;
    logic [DIM_W-1:0] hi_fixed;
    logic [DIM_W-1:0] lo_cur;

    logic              div_go;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [Q_W-1:0]    div_quotient;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              rd_valid;

    assign busy      = state_reg != S_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign sw = (32'(source_width_reg) > MAX_SOURCE_WIDTH) ?
                DIM_W'(MAX_SOURCE_WIDTH) : source_width_reg;
    assign sh = (32'(source_height_reg) > MAX_SOURCE_HEIGHT) ?
                DIM_W'(MAX_SOURCE_HEIGHT) : source_height_reg;

    always_comb
    begin
        if (sw < thumb_width_reg || sh < thumb_height_reg)
        begin
            cmp_err = ERR_SIZE;
        end
        else if ({1'b0, request.col} >= thumb_width_reg ||
                 {1'b0, request.row} >= thumb_height_reg)
        begin
            cmp_err = ERR_RANGE;
        end
        else
        begin
            cmp_err = ERR_OK;
        end
    end

    // load path
    assign load_ok = 32'(request.col) < MAX_SOURCE_WIDTH &&
                     32'(request.row) < MAX_SOURCE_HEIGHT;
    assign wr_en   = accept && request.action == ACT_LOAD && load_ok;
    assign wr_addr = ADDR_W'(32'(request.row) * MAX_SOURCE_WIDTH + 32'(request.col));
    assign wr_data = {request.red_in, request.green_in, request.blue_in};

    // box walk reads
    assign rd_en   = state_reg == S_WALK;
    assign rd_addr = row_base_reg + ADDR_W'(sx_reg);

    assign box_w = x1_reg - x0_reg;
    assign box_h = y1_reg - y0_reg;

    // divider operands
    always_comb
    begin
        div_go = state_reg == S_DIV_GO;
        case (op_reg)
            OP_LO_X:
            begin
                div_dividend = DIVD_W'(cx_reg);
                div_divisor  = DIVS_W'(thumb_width_reg);
            end
            OP_HI_X:
            begin
                div_dividend = DIVD_W'(cx_reg) + DIVD_W'(sw) + DIVD_W'(thumb_width_reg)
                               - DIVD_W'(1);
                div_divisor  = DIVS_W'(thumb_width_reg);
            end
            OP_LO_Y:
            begin
                div_dividend = DIVD_W'(cy_reg);
                div_divisor  = DIVS_W'(thumb_height_reg);
            end
            OP_HI_Y:
            begin
                div_dividend = DIVD_W'(cy_reg) + DIVD_W'(sh) + DIVD_W'(thumb_height_reg)
                               - DIVD_W'(1);
                div_divisor  = DIVS_W'(thumb_height_reg);
            end
            OP_BLUE:
            begin
                div_dividend = DIVD_W'(sum_b_reg);
                div_divisor  = DIVS_W'(area_reg);
            end
            OP_GREEN:
            begin
                div_dividend = DIVD_W'(sum_g_reg);
                div_divisor  = DIVS_W'(area_reg);
            end
            OP_RED:
            begin
                div_dividend = DIVD_W'(sum_r_reg);
                div_divisor  = DIVS_W'(area_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // box is at least one pixel wide
    assign lo_cur   = (op_reg == OP_HI_X) ? x0_reg : y0_reg;
    assign hi_fixed = (DIM_W'(div_quotient) <= lo_cur) ? lo_cur + DIM_W'(1) :
                      DIM_W'(div_quotient);

    bxds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bxds_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= SOURCE_WIDTH_RST;
            source_height_reg <= SOURCE_HEIGHT_RST;
            thumb_width_reg   <= THUMB_WIDTH_RST;
            thumb_height_reg  <= THUMB_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_THUMB_WIDTH:   thumb_width_reg   <= cfg_data;
                CFG_THUMB_HEIGHT:  thumb_height_reg  <= cfg_data;
                default:           source_width_reg  <= source_width_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_LO_X;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (rd_valid)
            begin
                sum_r_reg <= sum_r_reg + SUM_W'(rd_data[3*CH_W-1:2*CH_W]);
                sum_g_reg <= sum_g_reg + SUM_W'(rd_data[2*CH_W-1:CH_W]);
                sum_b_reg <= sum_b_reg + SUM_W'(rd_data[CH_W-1:0]);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && request.action == ACT_COMPUTE)
                    begin
                        if (cmp_err != ERR_OK)
                        begin
                            done_reg             <= 1'b1;
                            result_reg.blue_out  <= '0;
                            result_reg.green_out <= '0;
                            result_reg.red_out   <= '0;
                            result_reg.error     <= cmp_err;
                        end
                        else
                        begin
                            col_reg   <= request.col;
                            row_reg   <= request.row;
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP:
                begin
                    cx_reg    <= AREA_W'(col_reg) * AREA_W'(sw);
                    cy_reg    <= AREA_W'(row_reg) * AREA_W'(sh);
                    op_reg    <= OP_LO_X;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV_GO;
                        case (op_reg)
                            OP_LO_X:
                            begin
                                x0_reg <= DIM_W'(div_quotient);
                                op_reg <= OP_HI_X;
                            end
                            OP_HI_X:
                            begin
                                x1_reg <= hi_fixed;
                                op_reg <= OP_LO_Y;
                            end
                            OP_LO_Y:
                            begin
                                y0_reg <= DIM_W'(div_quotient);
                                op_reg <= OP_HI_Y;
                            end
                            OP_HI_Y:
                            begin
                                y1_reg    <= hi_fixed;
                                state_reg <= S_AREA;
                            end
                            OP_BLUE:
                            begin
                                mean_b_reg <= div_quotient[CH_W-1:0];
                                op_reg     <= OP_GREEN;
                            end
                            OP_GREEN:
                            begin
                                mean_g_reg <= div_quotient[CH_W-1:0];
                                op_reg     <= OP_RED;
                            end
                            OP_RED:
                            begin
                                done_reg             <= 1'b1;
                                result_reg.blue_out  <= mean_b_reg;
                                result_reg.green_out <= mean_g_reg;
                                result_reg.red_out   <= div_quotient[CH_W-1:0];
                                result_reg.error     <= ERR_OK;
                                state_reg            <= S_IDLE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_AREA:
                begin
                    area_reg     <= AREA_W'(box_w) * AREA_W'(box_h);
                    sx_reg       <= x0_reg;
                    sy_reg       <= y0_reg;
                    row_base_reg <= ADDR_W'(32'(y0_reg) * MAX_SOURCE_WIDTH);
                    sum_r_reg    <= '0;
                    sum_g_reg    <= '0;
                    sum_b_reg    <= '0;
                    state_reg    <= S_WALK;
                end
                S_WALK:
                begin
                    if (sx_reg == x1_reg - DIM_W'(1))
                    begin
                        sx_reg       <= x0_reg;
                        sy_reg       <= sy_reg + DIM_W'(1);
                        row_base_reg <= row_base_reg + ADDR_W'(MAX_SOURCE_WIDTH);
                        if (sy_reg == y1_reg - DIM_W'(1))
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    else
                    begin
                        sx_reg <= sx_reg + DIM_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    op_reg    <= OP_BLUE;
                    state_reg <= S_DIV_GO;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a compute is at work");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.action == ACT_LOAD) |=> (!done && !busy))
        else $error("load request gave a result or started work");

    a_compute_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.action == ACT_COMPUTE && cmp_err == ERR_OK) |=> busy)
        else $error("valid compute request did not start");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error != ERR_OK) |->
        (result.blue_out == '0 && result.green_out == '0 && result.red_out == '0))
        else $error("error result carries color data");

endmodule
